/* sv/tsr_pkg.sv */
package tsr_pkg;

   localparam int LETTER_W = 5;

   // Search modes of the word being matched.
   localparam logic [1:0] MODE_FOLLOW  = 2'd0;
   localparam logic [1:0] MODE_MATCHED = 2'd1;
   localparam logic [1:0] MODE_BROKEN  = 2'd2;

   localparam logic KIND_LETTER = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   localparam logic STATUS_STORED = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [LETTER_W-1:0] out_letter;
      logic                word_end;
      logic                status;
   } rsp_type;

endpackage

/* sv/trie_shortest_root_replacer_top.sv */
// Shortest-root replacer over a trie held in one synchronous node memory.
// Input channel req_*: one letter per transfer with op (0 = dictionary root,
// 1 = sentence word) and a last-of-word mark. Result channel rsp_*: at most one
// result per input transfer, either an echoed sentence letter (kind 0) or the
// outcome of a root insert on its last letter (kind 1, status 1 = pool full).
// The child entry of each item is read from the node memory in the cycle of
// acceptance and is modified and written back in the next. A result is offered
// from the cycle after that. A new item is taken only once the last one has been
// written back, since the read and the write back share the one node memory.
// A two-entry result buffer lets work go on while the receiver stalls; input
// is also stalled once both entries hold results.
// After reset the node memory is cleared one entry per cycle, all NODES*ALPHABET
// entries (26624 with the defaults), and req_stall stays high meanwhile.
// Each memory entry holds a child index plus the root-end flag of that child.
module trie_shortest_root_replacer_top #(
   parameter int NODES    = 1024,
   parameter int ALPHABET = 26
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [tsr_pkg::LETTER_W-1:0] req_letter,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [tsr_pkg::LETTER_W-1:0] rsp_out_letter,
   output logic                         rsp_word_end,
   output logic                         rsp_status
);
   import tsr_pkg::*;

   localparam int NW    = $clog2(NODES);
   localparam int EW    = NW + 1;
   localparam int DEPTH = NODES * ALPHABET;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [EW-1:0] trie_mem [DEPTH];

   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [EW-1:0]       rd_ff;
   logic                op_ff, last_ff, inrng_ff, par_ff;
   logic [LETTER_W-1:0] letter_ff;
   logic [AW-1:0]       addr_ff;

   logic [NW-1:0] icur_ff, icur_in;
   logic [AW-1:0] ipar_ff, ipar_in;
   logic          iovf_ff, iovf_in;
   logic [NW:0]   free_ff, free_in;
   logic [NW-1:0] qcur_ff, qcur_in;
   logic [1:0]    qmode_ff, qmode_in;

   logic                accept;
   logic                buf_full;
   logic                req_inrng;
   logic [LETTER_W-1:0] let_idx;
   logic                par_cond;
   logic [AW-1:0]       ins_addr, qry_addr, rd_addr;

   logic          mem_we, exec_we;
   logic [AW-1:0] mem_wa;
   logic [EW-1:0] mem_wd, exec_wd;

   logic          push;
   rsp_type       push_data, head;

   logic [NW-1:0] rd_child;
   logic          rd_end;
   logic [NW-1:0] nxt;
   logic          ovf_v, step, emit, wend;

   // ---------------------------------------------------------------- accept side
   assign req_stall = !(state_ff == S_IDLE && !buf_full);
   assign accept    = req_valid && !req_stall;

   assign req_inrng = (int'(req_letter) < ALPHABET);
   assign let_idx   = req_inrng ? req_letter : '0;
   assign ins_addr  = AW'(icur_ff) * AW'(ALPHABET) + AW'(let_idx);
   assign qry_addr  = AW'(qcur_ff) * AW'(ALPHABET) + AW'(let_idx);

   // An ignored letter that ends a root marks the current node, whose flag
   // lives in the entry of its parent.
   assign par_cond = !req_inrng && req_last && !iovf_ff && (icur_ff != '0);
   assign rd_addr  = req_op ? qry_addr : (par_cond ? ipar_ff : ins_addr);

   // ---------------------------------------------------------------- execute side
   assign rd_child = rd_ff[NW-1:0];
   assign rd_end   = rd_ff[NW];

   always_comb begin
      icur_in   = icur_ff;
      ipar_in   = ipar_ff;
      iovf_in   = iovf_ff;
      free_in   = free_ff;
      qcur_in   = qcur_ff;
      qmode_in  = qmode_ff;
      exec_we   = 1'b0;
      exec_wd   = rd_ff;
      push      = 1'b0;
      push_data = '0;
      nxt       = rd_child;
      ovf_v     = iovf_ff;
      step      = 1'b0;
      emit      = 1'b0;
      wend      = last_ff;
      if (state_ff == S_EXEC) begin
         if (op_ff == 1'b0) begin
            if (!iovf_ff && inrng_ff) begin
               if (rd_child == '0) begin
                  if (free_ff < (NW+1)'(NODES)) begin
                     nxt     = free_ff[NW-1:0];
                     free_in = free_ff + 1'b1;
                     exec_we = 1'b1;
                  end else begin
                     ovf_v = 1'b1;
                  end
               end
               step = !ovf_v;
            end
            exec_wd = {rd_end, nxt};
            if (last_ff) begin
               if (!ovf_v) begin
                  if (step) begin
                     exec_we = 1'b1;
                     exec_wd = {1'b1, nxt};
                  end else if (par_ff) begin
                     exec_we = 1'b1;
                     exec_wd = {1'b1, rd_child};
                  end
               end
               icur_in              = '0;
               iovf_in              = 1'b0;
               push                 = 1'b1;
               push_data.kind       = KIND_INSERT;
               push_data.status     = ovf_v ? STATUS_FULL : STATUS_STORED;
            end else begin
               iovf_in = ovf_v;
               if (step) begin
                  icur_in = nxt;
                  ipar_in = addr_ff;
               end
            end
         end else begin
            case (qmode_ff)
               MODE_FOLLOW: begin
                  emit = 1'b1;
                  if (!inrng_ff || rd_child == '0) begin
                     qmode_in = MODE_BROKEN;
                  end else begin
                     qcur_in = rd_child;
                     if (rd_end) begin
                        qmode_in = MODE_MATCHED;
                        wend     = 1'b1;
                     end
                  end
               end
               MODE_BROKEN: begin
                  emit = 1'b1;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
            if (last_ff) begin
               qcur_in  = '0;
               qmode_in = MODE_FOLLOW;
            end
            push                 = emit;
            push_data.kind       = KIND_LETTER;
            push_data.out_letter = letter_ff;
            push_data.word_end   = wend;
            push_data.status     = STATUS_STORED;
         end
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         icur_ff  <= '0;
         iovf_ff  <= 1'b0;
         free_ff  <= (NW+1)'(1);
         qcur_ff  <= '0;
         qmode_ff <= MODE_FOLLOW;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         icur_ff  <= icur_in;
         iovf_ff  <= iovf_in;
         free_ff  <= free_in;
         qcur_ff  <= qcur_in;
         qmode_ff <= qmode_in;
      end
   end

   always_ff @(posedge clock) begin
      ipar_ff <= ipar_in;
      if (accept) begin
         op_ff     <= req_op;
         letter_ff <= req_letter;
         last_ff   <= req_last;
         inrng_ff  <= req_inrng;
         par_ff    <= par_cond;
         addr_ff   <= rd_addr;
      end
   end

   // ---------------------------------------------------------------- node memory
   assign mem_we = (state_ff == S_CLEAR) || exec_we;
   assign mem_wa = (state_ff == S_CLEAR) ? clr_ff : addr_ff;
   assign mem_wd = (state_ff == S_CLEAR) ? '0 : exec_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         trie_mem[mem_wa] <= mem_wd;
      end
      if (accept) begin
         rd_ff <= trie_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- results
   tsr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind       = head.kind;
   assign rsp_out_letter = head.out_letter;
   assign rsp_word_end   = head.word_end;
   assign rsp_status     = head.status;

`ifndef NO_ASSERTIONS
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted item not executed in the next cycle");

   a_insert_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff == 1'b0 && !last_ff) |-> !push)
      else $error("insert result produced before the last letter of a root");

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff != '0 && free_ff <= (NW+1)'(NODES))
      else $error("free node count out of range");

   a_ovf_pool: assert property (@(posedge clock) disable iff (reset)
      iovf_ff |-> free_ff == (NW+1)'(NODES))
      else $error("insert overflow flagged while nodes remain");
`endif

endmodule

/* sv/tsr_rsp_buf.sv */
module tsr_rsp_buf (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tsr_pkg::rsp_type push_data,
   output logic            full,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output tsr_pkg::rsp_type head
);
   import tsr_pkg::*;

   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign full      = (cnt_ff == 2'd2);
   assign head      = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (push && !pop) begin
         if (cnt_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end else if (pop && push) begin
         // The head leaves while a new transfer arrives behind it.
         if (cnt_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !(full && !pop))
      else $error("result pushed into a full buffer");

   a_second_slot: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1 && push && !pop) |=> (cnt_ff == 2'd2 && slot1_ff == $past(push_data)))
      else $error("queued result not held behind the head");
`endif

endmodule

/* bench/trie_shortest_root_replacer_top_test.sv */
module trie_shortest_root_replacer_top_test;
   import tsr_pkg::*;

   localparam int NODES      = 1024;
   localparam int ALPHABET   = 26;
   localparam int IDLE_LIMIT = 100000;
   localparam int HOLD_LEN   = 400;

   localparam logic OP_ROOT = 1'b0;
   localparam logic OP_WORD = 1'b1;

   typedef struct packed {
      logic                op;
      logic [LETTER_W-1:0] letter;
      logic                last;
   } letter_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_op = 1'b0;
   logic [LETTER_W-1:0] req_letter = '0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_kind;
   logic [LETTER_W-1:0] rsp_out_letter;
   logic                rsp_word_end;
   logic                rsp_status;

   trie_shortest_root_replacer_top #(
      .NODES   (NODES),
      .ALPHABET(ALPHABET)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_letter    (req_letter),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_out_letter(rsp_out_letter),
      .rsp_word_end  (rsp_word_end),
      .rsp_status    (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicted trie contents and cursors.
   logic [9:0]  trie_kids [NODES*ALPHABET];
   logic        root_end [NODES];
   logic [10:0] next_free;
   logic [9:0]  ins_node;
   logic        ins_full;
   logic [9:0]  word_node;
   logic [1:0]  word_mode;

   letter_item_type letters_to_send[$];
   rsp_type         outcomes_due[$];

   // Roots sent so far, kept so that sentence words can follow them.
   logic [LETTER_W-1:0] root_chars[$];
   int                  root_start[$];
   int                  root_len[$];
   logic [LETTER_W-1:0] word_buf[$];

   int items_taken   = 0;
   int results_taken = 0;
   int queued_items  = 0;
   int failures      = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   function automatic bit shorten_step(input logic op, input logic [LETTER_W-1:0] ltr,
                                       input logic lst, output rsp_type r);
      logic [9:0] nxt;
      bit         has;
      r   = '0;
      has = 1'b0;
      if (op == OP_ROOT) begin
         if (!ins_full && ltr < ALPHABET) begin
            nxt = trie_kids[ins_node * ALPHABET + ltr];
            if (nxt == '0) begin
               if (next_free < NODES) begin
                  nxt = next_free[9:0];
                  next_free = next_free + 1'b1;
                  trie_kids[ins_node * ALPHABET + ltr] = nxt;
               end else begin
                  ins_full = 1'b1;
               end
            end
            if (!ins_full)
               ins_node = nxt;
         end
         if (lst) begin
            r.kind   = KIND_INSERT;
            r.status = ins_full ? STATUS_FULL : STATUS_STORED;
            if (!ins_full)
               root_end[ins_node] = 1'b1;
            ins_node = '0;
            ins_full = 1'b0;
            has      = 1'b1;
         end
      end else begin
         r.kind       = KIND_LETTER;
         r.out_letter = ltr;
         r.word_end   = lst;
         if (word_mode == MODE_FOLLOW) begin
            nxt = '0;
            if (ltr < ALPHABET)
               nxt = trie_kids[word_node * ALPHABET + ltr];
            if (nxt == '0) begin
               word_mode = MODE_BROKEN;
            end else begin
               word_node = nxt;
               if (root_end[word_node]) begin
                  word_mode  = MODE_MATCHED;
                  r.word_end = 1'b1;
               end
            end
            has = 1'b1;
         end else if (word_mode == MODE_BROKEN) begin
            has = 1'b1;
         end
         if (lst) begin
            word_node = '0;
            word_mode = MODE_FOLLOW;
         end
      end
      return has;
   endfunction

   function automatic bit calm_window();
      return items_taken >= 600 && items_taken < 800;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic logic [LETTER_W-1:0] pick_letter();
      if ($urandom_range(99) < 6)
         return LETTER_W'($urandom_range(31, ALPHABET));
      return LETTER_W'($urandom_range(ALPHABET - 1, 0));
   endfunction

   always @(posedge clock) begin : feed
      rsp_type         r;
      letter_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            items_taken = items_taken + 1;
            if (shorten_step(req_op, req_letter, req_last, r))
               outcomes_due.push_back(r);
         end
         if (!req_valid || !req_stall) begin
            if (letters_to_send.size() != 0 && (calm_window() || $urandom_range(99) >= 31)) begin
               nxt = letters_to_send.pop_front();
               req_valid  <= 1'b1;
               req_op     <= nxt.op;
               req_letter <= nxt.letter;
               req_last   <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : observe
      rsp_type want;
      bit      stall_next;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_taken = results_taken + 1;
            if (outcomes_due.size() == 0) begin
               $error("unexpected result: kind %0d letter %0d word_end %0d status %0d",
                      rsp_kind, rsp_out_letter, rsp_word_end, rsp_status);
               failures++;
            end else begin
               want = outcomes_due.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("out_letter", want.out_letter, rsp_out_letter);
               check_field("word_end", want.word_end, rsp_word_end);
               check_field("status", want.status, rsp_status);
            end
         end
         // One long hold-off lets the result buffer fill and back up the input.
         if (!hold_done && results_taken >= 300) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            stall_next = 1'b1;
         end else begin
            stall_next = !calm_window() && $urandom_range(99) < 31;
         end
         rsp_stall <= stall_next;
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("Regression FAIL");
      $finish;
   end

   task automatic push_item(input logic op, input logic [LETTER_W-1:0] ltr, input logic lst);
      letter_item_type it;
      while (letters_to_send.size() >= 8)
         @(posedge clock);
      it.op     = op;
      it.letter = ltr;
      it.last   = lst;
      letters_to_send.push_back(it);
      queued_items++;
   endtask

   // Sends word_buf as one root or word, the last letter marked.
   task automatic queue_word(input logic op);
      bit clean;
      clean = 1'b1;
      foreach (word_buf[i]) begin
         if (word_buf[i] >= ALPHABET)
            clean = 1'b0;
      end
      if (op == OP_ROOT && clean && root_len.size() < 600) begin
         root_start.push_back(root_chars.size());
         root_len.push_back(word_buf.size());
         foreach (word_buf[i])
            root_chars.push_back(word_buf[i]);
      end
      foreach (word_buf[i])
         push_item(op, word_buf[i], i == word_buf.size() - 1);
      word_buf.delete();
   endtask

   task automatic queue_text(input logic op, input string s);
      for (int i = 0; i < s.len(); i++)
         word_buf.push_back(LETTER_W'(s[i] - "a"));
      queue_word(op);
   endtask

   task automatic take_known_prefix(input int most);
      int idx;
      int k;
      idx = $urandom_range(root_len.size() - 1, 0);
      k   = $urandom_range(root_len[idx] < most ? root_len[idx] : most, 1);
      for (int i = 0; i < k; i++)
         word_buf.push_back(root_chars[root_start[idx] + i]);
   endtask

   task automatic make_sequence(input bit long_roots);
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < (long_roots ? 85 : 40)) begin
         // Some roots extend a stored one, so that overflow can strike mid-path.
         if (root_len.size() != 0 && $urandom_range(3) == 0)
            take_known_prefix(long_roots ? 8 : 30);
         n = long_roots ? $urandom_range(40, 30) : $urandom_range(10, 1);
         repeat (n)
            word_buf.push_back(pick_letter());
         queue_word(OP_ROOT);
      end else if (pick < (long_roots ? 95 : 80) && root_len.size() != 0) begin
         take_known_prefix(40);
         repeat ($urandom_range(4, 0))
            word_buf.push_back(pick_letter());
         queue_word(OP_WORD);
      end else if (pick < 92) begin
         repeat ($urandom_range(8, 1))
            word_buf.push_back(pick_letter());
         queue_word(OP_WORD);
      end else begin
         repeat ($urandom_range(4, 1))
            push_item(1'($urandom_range(1)), LETTER_W'($urandom_range(31)),
                      1'($urandom_range(1)));
      end
   endtask

   initial begin
      for (int i = 0; i < NODES * ALPHABET; i++)
         trie_kids[i] = '0;
      for (int i = 0; i < NODES; i++)
         root_end[i] = 1'b0;
      next_free = 11'd1;
      ins_node  = '0;
      ins_full  = 1'b0;
      word_node = '0;
      word_mode = MODE_FOLLOW;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      queue_text(OP_WORD, "a");        // empty trie, the path breaks at once
      queue_text(OP_ROOT, "ca");
      queue_text(OP_ROOT, "cat");
      queue_text(OP_WORD, "cattle");   // the shorter root wins, the tail is dropped
      queue_text(OP_WORD, "c");        // prefix of a root but no root end
      push_item(OP_ROOT, 5'd31, 1'b1); // a root of ignored letters stores nothing but is still reported as stored
      push_item(OP_WORD, 5'd31, 1'b1); // an out-of-range sentence letter breaks the path
      // Root "be" and word "dog" interleaved, with an ignored letter inside the root.
      push_item(OP_WORD, LETTER_W'("d" - "a"), 1'b0);
      push_item(OP_ROOT, LETTER_W'("b" - "a"), 1'b0);
      push_item(OP_WORD, LETTER_W'("o" - "a"), 1'b0);
      push_item(OP_ROOT, 5'd26, 1'b0);
      push_item(OP_ROOT, LETTER_W'("e" - "a"), 1'b1);
      push_item(OP_WORD, LETTER_W'("g" - "a"), 1'b1);
      queue_text(OP_WORD, "bez");
      push_item(OP_WORD, 5'd0, 1'b0);
      push_item(OP_WORD, 5'd25, 1'b1);

      // Random traffic, then longer roots until the node pool is used up, then a tail
      // that runs against the full pool.
      while (queued_items < 1050 || next_free < NODES)
         make_sequence(queued_items >= 100);
      repeat (8)
         make_sequence(1'b0);

      while (letters_to_send.size() != 0 || req_valid)
         @(posedge clock);
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0 && outcomes_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
